>>> hw/rtl/tlbfl_pkg.sv
// ----------------------------------------------------------------------------
// tlbfl_pkg
// Shared types and constants of the FIFO/LRU translation lookaside buffer.
// ----------------------------------------------------------------------------
package tlbfl_pkg;

  localparam int DEF_TLB_DEPTH  = 16;
  localparam int DEF_PAGE_BITS  = 20;
  localparam int DEF_FRAME_BITS = 20;
  localparam int DEF_PROC_BITS  = 16;

  localparam int STAMP_W    = 32;
  localparam int CMD_W      = 2;
  localparam int CFG_CNT_W  = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_ADDR_W = 1;

  // transaction commands
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // replacement policy
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_LRU  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ENTRIES = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE    = 1'd1;

  localparam logic [CFG_CNT_W-1:0] CFG_ENTRIES_RST = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic req_load;
    logic res_clear;
    logic res_hit;
    logic hit_stamp;
    logic ins_free;
    logic ins_fifo;
    logic scan_start;
    logic scan_step;
    logic ins_victim;
    logic flush;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             mode;
    logic             n_zero;
    logic             hit;
    logic             free_any;
    logic             scan_done;
    logic             out_free;
  } dp_sts_t;

endpackage

>>> hw/rtl/tlb_fifo_lru_replacement_core.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replacement_core
// Fully associative TLB tagged by process id and page, with FIFO or LRU
// replacement. Each transaction (lookup, insert or process flush) gives one
// result: hit and frame for a lookup, zeros otherwise. Transactions are taken
// one at a time; a lookup, flush, insert into a free entry or FIFO
// replacement passes through accept, parallel tag compare and update, and
// result load, and the next transaction is accepted only after the result
// is loaded into the output register. An LRU replacement adds a stamp scan
// of one entry per cycle over the n entries in use, the last step of which
// writes the victim. A result load waits while the output register
// holds a result that has not been taken. The output register lets the next
// transaction be accepted while a result waits.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_replacement_core #(
  parameter int TLB_DEPTH  = tlbfl_pkg::DEF_TLB_DEPTH,
  parameter int PAGE_BITS  = tlbfl_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS = tlbfl_pkg::DEF_FRAME_BITS,
  parameter int PROC_BITS  = tlbfl_pkg::DEF_PROC_BITS,
  localparam int IN_DATA_W  = ((PROC_BITS + PAGE_BITS + FRAME_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((FRAME_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_DATA_W-1:0]             in_tdata,   // proc_id, page_number, frame_in
  input  logic [tlbfl_pkg::CMD_W-1:0]      in_tuser,   // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [OUT_DATA_W-1:0]            out_tdata,  // frame_out
  output logic                             out_tuser,  // hit
  input  logic                             cfg_we,
  input  logic [tlbfl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlbfl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tlbfl_pkg::*;

  dp_cmd_t               cmd;
  dp_sts_t               sts;
  logic [FRAME_BITS-1:0] out_frame;

  tlbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlbfl_dp #(
    .TLB_DEPTH  (TLB_DEPTH),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS),
    .PROC_BITS  (PROC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_cmd    (in_tuser),
    .req_proc   (in_tdata[PROC_BITS-1:0]),
    .req_page   (in_tdata[PROC_BITS+PAGE_BITS-1:PROC_BITS]),
    .req_frame  (in_tdata[PROC_BITS+PAGE_BITS+FRAME_BITS-1:PROC_BITS+PAGE_BITS]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_hit    (out_tuser),
    .out_frame  (out_frame),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign out_tdata = OUT_DATA_W'(out_frame);

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("transaction accepted while another is in progress");

  a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ins_free, cmd.ins_fifo, cmd.ins_victim, cmd.hit_stamp, cmd.flush}))
    else $error("more than one entry update in a cycle");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !sts.scan_done)
    else $error("lru scan stepped past the entries in use");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("nonzero frame on a miss");
`endif

endmodule

>>> hw/rtl/tlbfl_ctrl.sv
// ----------------------------------------------------------------------------
// tlbfl_ctrl
// Sequencer of the TLB: accepts a transaction, evaluates it, runs the LRU
// victim scan when needed and hands the result to the output register.
// ----------------------------------------------------------------------------
module tlbfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tlbfl_pkg::dp_sts_t sts,
  output tlbfl_pkg::dp_cmd_t cmd
);
  import tlbfl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_RESP;
        case (sts.cmd)
          CMD_LOOKUP: begin
            if (sts.hit) begin
              cmd.res_hit   = 1'b1;
              cmd.hit_stamp = (sts.mode == MODE_LRU);
            end else begin
              cmd.res_clear = 1'b1;
            end
          end
          CMD_INSERT: begin
            cmd.res_clear = 1'b1;
            if (!sts.n_zero) begin
              if (sts.free_any) begin
                cmd.ins_free = 1'b1;
              end else if (sts.mode == MODE_FIFO) begin
                cmd.ins_fifo = 1'b1;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
          end
          CMD_FLUSH: begin
            cmd.res_clear = 1'b1;
            cmd.flush     = 1'b1;
          end
          default: begin
            cmd.res_clear = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.ins_victim = 1'b1;
          state_nxt      = S_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/tlbfl_dp.sv
// ----------------------------------------------------------------------------
// tlbfl_dp
// Datapath of the TLB: entry registers, parallel tag compare, free search,
// FIFO pointer, stamp counter, LRU scan registers and the output register.
// ----------------------------------------------------------------------------
module tlbfl_dp #(
  parameter int TLB_DEPTH  = tlbfl_pkg::DEF_TLB_DEPTH,
  parameter int PAGE_BITS  = tlbfl_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS = tlbfl_pkg::DEF_FRAME_BITS,
  parameter int PROC_BITS  = tlbfl_pkg::DEF_PROC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tlbfl_pkg::CMD_W-1:0]      req_cmd,
  input  logic [PROC_BITS-1:0]             req_proc,
  input  logic [PAGE_BITS-1:0]             req_page,
  input  logic [FRAME_BITS-1:0]            req_frame,
  input  logic                             cfg_we,
  input  logic [tlbfl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tlbfl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic                             out_hit,
  output logic [FRAME_BITS-1:0]            out_frame,
  input  tlbfl_pkg::dp_cmd_t               cmd,
  output tlbfl_pkg::dp_sts_t               sts
);
  import tlbfl_pkg::*;

  localparam int IDX_W = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int CNT_W = $clog2(TLB_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;

  // configuration
  logic [CFG_CNT_W-1:0] cfg_entries_r;
  logic                 cfg_mode_r;

  // request
  logic [CMD_W-1:0]      req_cmd_r;
  logic [PROC_BITS-1:0]  req_proc_r;
  logic [PAGE_BITS-1:0]  req_page_r;
  logic [FRAME_BITS-1:0] req_frame_r;

  // entries
  logic [TLB_DEPTH-1:0]  valid_r;
  logic [PROC_BITS-1:0]  proc_r  [TLB_DEPTH];
  logic [PAGE_BITS-1:0]  page_r  [TLB_DEPTH];
  logic [FRAME_BITS-1:0] frame_r [TLB_DEPTH];
  logic [STAMP_W-1:0]    stamp_r [TLB_DEPTH];

  logic [STAMP_W-1:0] stamp_ctr_r;
  logic [STAMP_W-1:0] stamp_ctr_nxt;
  logic [IDX_W-1:0]   fifo_ptr_r;
  logic [IDX_W-1:0]   fifo_ptr_nxt;

  // lru scan
  logic [CNT_W-1:0]   scan_idx_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic [STAMP_W-1:0] scan_stamp;

  // result and output
  logic                  res_hit_r;
  logic [FRAME_BITS-1:0] res_frame_r;
  logic                  out_tvalid_r;
  logic                  out_hit_r;
  logic [FRAME_BITS-1:0] out_frame_r;

  logic [CMP_W-1:0]     cnt_ext;
  logic [CNT_W-1:0]     n_act;
  logic [TLB_DEPTH-1:0] en_vec;
  logic [TLB_DEPTH-1:0] hit_vec;
  logic [TLB_DEPTH-1:0] free_vec;
  logic [TLB_DEPTH-1:0] flush_vec;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     free_idx;
  logic [IDX_W-1:0]     fifo_v;
  logic [CNT_W-1:0]     fifo_inc;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;

  assign cnt_ext = CMP_W'(cfg_entries_r);
  assign n_act   = (cnt_ext > CMP_W'(TLB_DEPTH)) ? CNT_W'(TLB_DEPTH) : CNT_W'(cnt_ext);

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      en_vec[i]    = (CNT_W'(i) < n_act);
      hit_vec[i]   = en_vec[i] && valid_r[i] && (proc_r[i] == req_proc_r)
                     && (page_r[i] == req_page_r);
      free_vec[i]  = en_vec[i] && !valid_r[i];
      flush_vec[i] = en_vec[i] && valid_r[i] && (proc_r[i] == req_proc_r);
    end
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // fifo victim and pointer advance
  assign fifo_v       = (CNT_W'(fifo_ptr_r) < n_act) ? fifo_ptr_r : '0;
  assign fifo_inc     = CNT_W'(fifo_v) + CNT_W'(1);
  assign fifo_ptr_nxt = (fifo_inc >= n_act) ? '0 : fifo_inc[IDX_W-1:0];

  assign scan_stamp = stamp_r[scan_idx_r[IDX_W-1:0]];

  assign wr_en = cmd.ins_free || cmd.ins_fifo || cmd.ins_victim;

  always_comb begin
    if (cmd.ins_free) begin
      wr_idx = free_idx;
    end else if (cmd.ins_fifo) begin
      wr_idx = fifo_v;
    end else begin
      wr_idx = best_idx_r;
    end
  end

  assign stamp_ctr_nxt = stamp_ctr_r + STAMP_W'(1);

  assign sts.cmd       = req_cmd_r;
  assign sts.mode      = cfg_mode_r;
  assign sts.n_zero    = (n_act == '0);
  assign sts.hit       = |hit_vec;
  assign sts.free_any  = |free_vec;
  assign sts.scan_done = (scan_idx_r >= n_act);
  assign sts.out_free  = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_hit    = out_hit_r;
  assign out_frame  = out_frame_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entries_r <= CFG_ENTRIES_RST;
      cfg_mode_r    <= MODE_FIFO;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENTRIES: cfg_entries_r <= cfg_wdata[CFG_CNT_W-1:0];
        CFG_MODE:    cfg_mode_r    <= cfg_wdata[0];
        default:     cfg_mode_r    <= cfg_mode_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      stamp_ctr_r  <= '0;
      fifo_ptr_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end else if (cmd.flush) begin
        valid_r <= valid_r & ~flush_vec;
      end
      if (wr_en || cmd.hit_stamp) begin
        stamp_ctr_r <= stamp_ctr_nxt;
      end
      if (cmd.ins_fifo) begin
        fifo_ptr_r <= fifo_ptr_nxt;
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_cmd_r   <= req_cmd;
      req_proc_r  <= req_proc;
      req_page_r  <= req_page;
      req_frame_r <= req_frame;
    end
    if (wr_en) begin
      proc_r[wr_idx]  <= req_proc_r;
      page_r[wr_idx]  <= req_page_r;
      frame_r[wr_idx] <= req_frame_r;
      stamp_r[wr_idx] <= stamp_ctr_r;
    end else if (cmd.hit_stamp) begin
      stamp_r[hit_idx] <= stamp_ctr_r;
    end
    if (cmd.scan_start) begin
      scan_idx_r   <= CNT_W'(1);
      best_idx_r   <= '0;
      best_stamp_r <= stamp_r[0];
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + CNT_W'(1);
      if (scan_stamp < best_stamp_r) begin
        best_idx_r   <= scan_idx_r[IDX_W-1:0];
        best_stamp_r <= scan_stamp;
      end
    end
    if (cmd.res_clear) begin
      res_hit_r   <= 1'b0;
      res_frame_r <= '0;
    end else if (cmd.res_hit) begin
      res_hit_r   <= 1'b1;
      res_frame_r <= frame_r[hit_idx];
    end
    if (cmd.out_load) begin
      out_hit_r   <= res_hit_r;
      out_frame_r <= res_frame_r;
    end
  end

endmodule
